[sv/lcdmts_pkg.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer package
// Display mode codes, configuration register indexes and timing constants
// shared by the sequencer and its checker.
// ----------------------------------------------------------------------------
package lcdmts_pkg;

    // Display modes, encoded as the status register reports them.
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_COMPARE  = 3'd0,
        REG_COMPARE_IRQ   = 3'd1,
        REG_VBLANK_STAT   = 3'd2,
        REG_SEARCH_IRQ    = 3'd3,
        REG_BACKGROUND_EN = 3'd4,
        REG_SPRITE_EN     = 3'd5
    } cfg_index_t;

    // Field widths.
    localparam int ELAPSED_W = 6;
    localparam int ACC_W     = 10;
    localparam int LINE_W    = 8;

    // Mode durations in ticks and line counts.
    localparam logic [ACC_W-1:0]  SEARCH_TICKS      = 10'd80;
    localparam logic [ACC_W-1:0]  TRANSFER_TICKS    = 10'd172;
    localparam logic [ACC_W-1:0]  HBLANK_TICKS      = 10'd204;
    localparam logic [ACC_W-1:0]  VBLANK_LINE_TICKS = 10'd456;
    localparam logic [LINE_W-1:0] VISIBLE_LINES     = 8'd144;
    localparam logic [LINE_W-1:0] TOTAL_LINES       = 8'd154;

    localparam logic [ACC_W-1:0]  ACC_MAX           = {ACC_W{1'b1}};

endpackage : lcdmts_pkg

[sv/lcd_mode_timing_sequencer.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer
// Tracks display mode, line counter and line-compare flag from elapsed cycle
// reports, and raises interrupt pulses and line draw strobes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, elapsed_cycles): each request reports
//   the clock cycles elapsed since the previous one.
//   Output channel (out_valid/out_ready): exactly one result per request,
//   carrying the mode and line after the step, the match flag, and the
//   vblank_irq, stat_irq, draw_background and draw_sprites pulses.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes
//   one register per request; cfg_ready is always high, unknown indexes are
//   ignored. Write only while no request is in flight.
//   Result: registered, valid in the cycle after the request is accepted.
//   Throughput: one request per cycle while out_ready is high; the add,
//   compare and subtract on the tick accumulator plus the line step fit
//   between the accepting edge and the result register.
//   Reset: mode horizontal blank, line 0, accumulator 0, match flag 0,
//   background drawing enabled and all other configuration registers cleared.
//   Stall: while a result waits on out_ready, in_ready stays low; it rises
//   again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module lcd_mode_timing_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lcdmts_pkg::ELAPSED_W-1:0]   elapsed_cycles,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         mode,
    output logic [lcdmts_pkg::LINE_W-1:0]      line,
    output logic                               line_match,
    output logic                               vblank_irq,
    output logic                               stat_irq,
    output logic                               draw_background,
    output logic                               draw_sprites,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lcdmts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcdmts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcdmts_pkg::*;

    // Configuration registers.
    logic [LINE_W-1:0] line_compare_reg;
    logic              compare_irq_enable_reg;
    logic              vblank_stat_enable_reg;
    logic              search_irq_enable_reg;
    logic              background_enable_reg;
    logic              sprite_enable_reg;

    // Sequencer state.
    mode_t             mode_reg, mode_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              match_reg, match_next;

    // Result register.
    logic              out_valid_reg;
    logic              vblank_irq_reg, vblank_irq_next;
    logic              stat_irq_reg, stat_irq_next;
    logic              draw_bg_reg, draw_bg_next;
    logic              draw_spr_reg, draw_spr_next;

    // Intermediate values.
    logic              in_accept;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [LINE_W:0]   line_inc;
    logic [LINE_W-1:0] line_stepped;
    logic              match_stepped;
    logic              compare_irq;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_compare_reg       <= '0;
            compare_irq_enable_reg <= 1'b0;
            vblank_stat_enable_reg <= 1'b0;
            search_irq_enable_reg  <= 1'b0;
            background_enable_reg  <= 1'b1;
            sprite_enable_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_LINE_COMPARE:  line_compare_reg       <= cfg_data[LINE_W-1:0];
                REG_COMPARE_IRQ:   compare_irq_enable_reg <= cfg_data[0];
                REG_VBLANK_STAT:   vblank_stat_enable_reg <= cfg_data[0];
                REG_SEARCH_IRQ:    search_irq_enable_reg  <= cfg_data[0];
                REG_BACKGROUND_EN: background_enable_reg  <= cfg_data[0];
                REG_SPRITE_EN:     sprite_enable_reg      <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Saturating accumulator add.
    assign acc_sum = {1'b0, acc_reg} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, elapsed_cycles};
    assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    // Line step with wrap at the total line count, and the new compare result.
    assign line_inc      = {1'b0, line_reg} + {{LINE_W{1'b0}}, 1'b1};
    assign line_stepped  = (line_inc >= {1'b0, TOTAL_LINES}) ? '0 : line_inc[LINE_W-1:0];
    assign match_stepped = (line_stepped == line_compare_reg);
    assign compare_irq   = compare_irq_enable_reg && match_stepped;

    // Mode transition logic: at most one transition per request.
    always_comb
    begin
        mode_next       = mode_reg;
        acc_next        = acc_sat;
        line_next       = line_reg;
        match_next      = match_reg;
        vblank_irq_next = 1'b0;
        stat_irq_next   = 1'b0;
        draw_bg_next    = 1'b0;
        draw_spr_next   = 1'b0;
        unique case (mode_reg)
            MODE_SEARCH:
            begin
                if (acc_sat >= SEARCH_TICKS)
                begin
                    acc_next  = acc_sat - SEARCH_TICKS;
                    mode_next = MODE_TRANSFER;
                end
            end
            MODE_TRANSFER:
            begin
                if (acc_sat >= TRANSFER_TICKS)
                begin
                    acc_next      = acc_sat - TRANSFER_TICKS;
                    draw_bg_next  = background_enable_reg;
                    draw_spr_next = sprite_enable_reg;
                    mode_next     = MODE_HBLANK;
                end
            end
            MODE_HBLANK:
            begin
                if (acc_sat >= HBLANK_TICKS)
                begin
                    acc_next   = acc_sat - HBLANK_TICKS;
                    line_next  = line_stepped;
                    match_next = match_stepped;
                    if (line_stepped == VISIBLE_LINES)
                    begin
                        mode_next       = MODE_VBLANK;
                        vblank_irq_next = 1'b1;
                        stat_irq_next   = compare_irq || vblank_stat_enable_reg;
                    end
                    else
                    begin
                        mode_next     = MODE_SEARCH;
                        stat_irq_next = compare_irq || search_irq_enable_reg;
                    end
                end
            end
            MODE_VBLANK:
            begin
                if (acc_sat >= VBLANK_LINE_TICKS)
                begin
                    acc_next      = acc_sat - VBLANK_LINE_TICKS;
                    line_next     = line_stepped;
                    match_next    = match_stepped;
                    stat_irq_next = compare_irq;
                    if (line_stepped == '0)
                    begin
                        mode_next     = MODE_SEARCH;
                        stat_irq_next = compare_irq || search_irq_enable_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // Sequencer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HBLANK;
            acc_reg       <= '0;
            line_reg      <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                mode_reg  <= mode_next;
                acc_reg   <= acc_next;
                line_reg  <= line_next;
                match_reg <= match_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pulse fields of the result register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            vblank_irq_reg <= vblank_irq_next;
            stat_irq_reg   <= stat_irq_next;
            draw_bg_reg    <= draw_bg_next;
            draw_spr_reg   <= draw_spr_next;
        end
    end

    // The state registers hold the mode, line and flag of the last result.
    assign out_valid       = out_valid_reg;
    assign mode            = mode_reg;
    assign line            = line_reg;
    assign line_match      = match_reg;
    assign vblank_irq      = vblank_irq_reg;
    assign stat_irq        = stat_irq_reg;
    assign draw_background = draw_bg_reg;
    assign draw_sprites    = draw_spr_reg;

endmodule : lcd_mode_timing_sequencer

[sv/lcdmts_checker.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer checker
// Port-level assertions on the sequencer, attached by a bind statement.
// ----------------------------------------------------------------------------
module lcdmts_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         mode,
    input logic [lcdmts_pkg::LINE_W-1:0]      line,
    input logic                               vblank_irq,
    input logic                               draw_background,
    input logic                               draw_sprites
);
    import lcdmts_pkg::*;

    // A stalled result holds its mode and line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(line))
        else $error("stalled result changed");

    // A request always produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request gave no result");

    // The vertical blank pulse comes only on entry at the first blank line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_irq |-> mode == MODE_VBLANK && line == VISIBLE_LINES)
        else $error("vblank pulse outside vblank entry");

    // Draw strobes only appear on a result that lands in horizontal blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (draw_background || draw_sprites) |-> mode == MODE_HBLANK)
        else $error("draw strobe outside transfer end");

    // The line counter never reaches the total line count.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line < TOTAL_LINES)
        else $error("line counter out of range");

endmodule : lcdmts_checker

bind lcd_mode_timing_sequencer lcdmts_checker u_lcdmts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .mode            (mode),
    .line            (line),
    .vblank_irq      (vblank_irq),
    .draw_background (draw_background),
    .draw_sprites    (draw_sprites)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// LCD mode timing sequencer testbench
// Feeds elapsed-cycle requests to the sequencer and checks every status
// result against a request-level software copy of the mode timing. A short
// table of hand-picked requests and register writes runs first. Random phases
// follow, with different register settings and random gaps on both channels.
// One phase holds the output off for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdmts_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Random phases: sender idle and receiver stall odds in percent.
    localparam int NUM_PHASES     = 6;
    localparam int PRESSURE_PHASE = 4;
    localparam int PHASE_SEND_IDLE  [NUM_PHASES] = '{0, 87, 0, 28, 0, 0};
    localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 87, 28, 0, 0};
    localparam int PHASE_ITEMS      [NUM_PHASES] = '{350, 300, 300, 350, 250, 250};

    typedef struct packed {
        mode_t             mode;
        logic [LINE_W-1:0] line;
        logic              line_match;
        logic              vblank_irq;
        logic              stat_irq;
        logic              draw_background;
        logic              draw_sprites;
    } lcd_status_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] value;
        logic                  known;
        lcd_status_t           status;
    } stim_row_t;

    // A request as offered, with a hand-written result where one is given.
    typedef struct packed {
        logic        known;
        lcd_status_t status;
    } offered_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ELAPSED_W-1:0]  elapsed_cycles;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            mode;
    logic [LINE_W-1:0]     line;
    logic                  line_match;
    logic                  vblank_irq;
    logic                  stat_irq;
    logic                  draw_background;
    logic                  draw_sprites;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcd_mode_timing_sequencer dut (.*);

    // Timing state as the block should hold it.
    mode_t             pred_mode  = MODE_HBLANK;
    logic [ACC_W-1:0]  pred_ticks = '0;
    logic [LINE_W-1:0] pred_line  = '0;
    logic              pred_match = 1'b0;

    // Register copies, at their reset values.
    logic [LINE_W-1:0] cfg_line_compare = '0;
    logic              cfg_compare_irq  = 1'b0;
    logic              cfg_vblank_stat  = 1'b0;
    logic              cfg_search_irq   = 1'b0;
    logic              cfg_background   = 1'b1;
    logic              cfg_sprites      = 1'b0;

    lcd_status_t pending_status_q [$];
    offered_t    offered_q [$];
    stim_row_t   directed_rows [32];

    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int hold_off_requests = 0;
    int mismatch_count    = 0;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Line step: wrap at the total line count and refresh the compare flag.
    // Returns the compare interrupt.
    function automatic logic step_line_counter();
        logic [LINE_W:0] nxt;
        nxt = {1'b0, pred_line} + 1'b1;
        if (nxt >= {1'b0, TOTAL_LINES})
            nxt = '0;
        pred_line  = nxt[LINE_W-1:0];
        pred_match = (pred_line == cfg_line_compare);
        return cfg_compare_irq && pred_match;
    endfunction

    // Adds one elapsed-cycle count and takes at most one mode transition.
    function automatic lcd_status_t advance_timing(input logic [ELAPSED_W-1:0] elapsed);
        lcd_status_t      res;
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] ticks;
        res = '0;
        sum = {1'b0, pred_ticks} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, elapsed};
        if (sum > {1'b0, ACC_MAX})
            sum = {1'b0, ACC_MAX};
        ticks = sum[ACC_W-1:0];
        case (pred_mode)
            MODE_SEARCH:
            begin
                if (ticks >= SEARCH_TICKS)
                begin
                    ticks     = ticks - SEARCH_TICKS;
                    pred_mode = MODE_TRANSFER;
                end
            end
            MODE_TRANSFER:
            begin
                if (ticks >= TRANSFER_TICKS)
                begin
                    ticks               = ticks - TRANSFER_TICKS;
                    res.draw_background = cfg_background;
                    res.draw_sprites    = cfg_sprites;
                    pred_mode           = MODE_HBLANK;
                end
            end
            MODE_HBLANK:
            begin
                if (ticks >= HBLANK_TICKS)
                begin
                    ticks        = ticks - HBLANK_TICKS;
                    res.stat_irq = step_line_counter();
                    if (pred_line == VISIBLE_LINES)
                    begin
                        pred_mode      = MODE_VBLANK;
                        res.vblank_irq = 1'b1;
                        res.stat_irq   = res.stat_irq | cfg_vblank_stat;
                    end
                    else
                    begin
                        pred_mode    = MODE_SEARCH;
                        res.stat_irq = res.stat_irq | cfg_search_irq;
                    end
                end
            end
            default:
            begin
                // Vertical blank lasts whole lines until the counter wraps.
                if (ticks >= VBLANK_LINE_TICKS)
                begin
                    ticks        = ticks - VBLANK_LINE_TICKS;
                    res.stat_irq = step_line_counter();
                    if (pred_line == '0)
                    begin
                        pred_mode    = MODE_SEARCH;
                        res.stat_irq = res.stat_irq | cfg_search_irq;
                    end
                end
            end
        endcase
        pred_ticks     = ticks;
        res.mode       = pred_mode;
        res.line       = pred_line;
        res.line_match = pred_match;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.value     = data;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [ELAPSED_W-1:0] cycles);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.value = {{(CFG_DATA_W - ELAPSED_W){1'b0}}, cycles};
        return r;
    endfunction

    // Flags are {line_match, vblank_irq, stat_irq, draw_background, draw_sprites}.
    function automatic stim_row_t known_row(input logic [ELAPSED_W-1:0] cycles, input mode_t m,
                                            input logic [LINE_W-1:0] ln, input logic [4:0] flags);
        stim_row_t r;
        r        = item_row(cycles);
        r.known  = 1'b1;
        r.status = {m, ln, flags};
        return r;
    endfunction

    // Offers one request after a random idle gap and waits for its acceptance.
    task automatic offer_item(input logic [ELAPSED_W-1:0] cycles, input logic known,
                              input lcd_status_t status);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        offered_q.push_back({known, status});
        in_valid       <= 1'b1;
        elapsed_cycles <= cycles;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops offering and waits until every result has been checked.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_status_q.size() != 0 || offered_q.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes every register; the upper data bits of the flags carry noise.
    // Enables are {compare, vblank stat, search, background, sprites}.
    task automatic program_settings(input logic [LINE_W-1:0] compare, input logic [4:0] enables);
        write_reg(REG_LINE_COMPARE, compare);
        write_reg(REG_COMPARE_IRQ, {7'($urandom), enables[4]});
        write_reg(REG_VBLANK_STAT, {7'($urandom), enables[3]});
        write_reg(REG_SEARCH_IRQ, {7'($urandom), enables[2]});
        write_reg(REG_BACKGROUND_EN, {7'($urandom), enables[1]});
        write_reg(REG_SPRITE_EN, {7'($urandom), enables[0]});
        write_reg(REG_SPARE_HI, 8'($urandom));
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int seen_holds;
        int hold_left;
        seen_holds = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && seen_holds != hold_off_requests)
            begin
                seen_holds = hold_off_requests;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: results are checked before the request of the same edge is
    // predicted, since a result always belongs to an earlier request.
    always @(posedge clk)
    begin
        lcd_status_t got;
        lcd_status_t want;
        offered_t    offer;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {mode, line, line_match, vblank_irq, stat_irq, draw_background,
                       draw_sprites};
                if (pending_status_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: expected none, actual mode %0d line %0d",
                             $time, mode, line);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_status_q.pop_front();
                    check_field("mode", want.mode, got.mode);
                    check_field("line", want.line, got.line);
                    check_field("line_match", want.line_match, got.line_match);
                    check_field("vblank_irq", want.vblank_irq, got.vblank_irq);
                    check_field("stat_irq", want.stat_irq, got.stat_irq);
                    check_field("draw_background", want.draw_background, got.draw_background);
                    check_field("draw_sprites", want.draw_sprites, got.draw_sprites);
                end
            end

            // Register writes are masked to the register width.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LINE_COMPARE:  cfg_line_compare = cfg_data;
                    REG_COMPARE_IRQ:   cfg_compare_irq  = cfg_data[0];
                    REG_VBLANK_STAT:   cfg_vblank_stat  = cfg_data[0];
                    REG_SEARCH_IRQ:    cfg_search_irq   = cfg_data[0];
                    REG_BACKGROUND_EN: cfg_background   = cfg_data[0];
                    REG_SPRITE_EN:     cfg_sprites      = cfg_data[0];
                    default:           ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                offer = offered_q.pop_front();
                want  = advance_timing(elapsed_cycles);
                pending_status_q.push_back(offer.known ? offer.status : want);
            end
        end
    end

    // Watchdog on cycles in which no request moves on any channel.
    initial
    begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Stimulus.
    initial
    begin
        logic [ELAPSED_W-1:0] cycles;
        logic [LINE_W-1:0]    compare;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        elapsed_cycles = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;

        directed_rows = '{
            // Spare indexes must leave every register alone.
            cfg_row(REG_SPARE_HI, 8'hFF),
            cfg_row(REG_SPARE_LO, 8'h00),
            // After reset the line equals the compare value, yet the flag is clear.
            known_row(6'd0,  MODE_HBLANK, 8'd0, 5'b00000),
            known_row(6'd63, MODE_HBLANK, 8'd0, 5'b00000),
            known_row(6'd63, MODE_HBLANK, 8'd0, 5'b00000),
            known_row(6'd63, MODE_HBLANK, 8'd0, 5'b00000),
            known_row(6'd63, MODE_SEARCH, 8'd1, 5'b00000),
            // Compare now equals the line; the flag waits for a line step.
            cfg_row(REG_LINE_COMPARE, 8'd1),
            cfg_row(REG_COMPARE_IRQ, 8'hFF),
            cfg_row(REG_SEARCH_IRQ, 8'h01),
            cfg_row(REG_BACKGROUND_EN, 8'hFE),
            cfg_row(REG_SPRITE_EN, 8'h81),
            // Exact thresholds leave the accumulator at zero.
            known_row(6'd32, MODE_TRANSFER, 8'd1, 5'b00000),
            known_row(6'd63, MODE_TRANSFER, 8'd1, 5'b00000),
            known_row(6'd63, MODE_TRANSFER, 8'd1, 5'b00000),
            known_row(6'd46, MODE_HBLANK, 8'd1, 5'b00001),
            known_row(6'd63, MODE_HBLANK, 8'd1, 5'b00000),
            known_row(6'd63, MODE_HBLANK, 8'd1, 5'b00000),
            known_row(6'd63, MODE_HBLANK, 8'd1, 5'b00000),
            known_row(6'd15, MODE_SEARCH, 8'd2, 5'b00100),
            known_row(6'd63, MODE_SEARCH, 8'd2, 5'b00000),
            known_row(6'd17, MODE_TRANSFER, 8'd2, 5'b00000),
            cfg_row(REG_VBLANK_STAT, 8'h01),
            cfg_row(REG_BACKGROUND_EN, 8'h01),
            cfg_row(REG_LINE_COMPARE, 8'hFF),
            cfg_row(REG_SPARE_LO, 8'hAA),
            item_row(6'd0),
            item_row(6'd42),
            item_row(6'd21),
            item_row(6'd63),
            item_row(6'd63),
            item_row(6'd63)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; registers are only written with nothing in flight.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(directed_rows[i].reg_index, directed_rows[i].value);
            end
            else
                offer_item(directed_rows[i].value[ELAPSED_W-1:0], directed_rows[i].known,
                           directed_rows[i].status);
        end

        // Random phases. Counts lean large so that frames complete and the
        // vertical blank is entered and left.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            if (p == 0)
                program_settings(8'd0, 5'b11111);
            else if (p == 1)
                program_settings(8'hFF, 5'b00000);
            else
            begin
                case ($urandom_range(0, 3))
                    0:       compare = VISIBLE_LINES;
                    1:       compare = TOTAL_LINES - 8'd1;
                    2:       compare = 8'($urandom_range(0, 153));
                    default: compare = 8'($urandom);
                endcase
                program_settings(compare, 5'($urandom));
            end
            send_idle_pct  = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            if (p == PRESSURE_PHASE)
                hold_off_requests++;
            repeat (PHASE_ITEMS[p])
            begin
                if ($urandom_range(0, 99) < 85)
                    cycles = 6'($urandom_range(40, 63));
                else
                    cycles = 6'($urandom_range(0, 63));
                offer_item(cycles, 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_status_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule : tb
